// ===== src/lbc_pkg.sv =====
// Shared types and constants of the LED blink controller.
`timescale 1ns / 1ps
package lbc_pkg;

  localparam int MASK_W   = 4;
  localparam int COUNT_W  = 8;
  localparam int PCT_W    = 8;
  localparam int DUTY_W   = 7;
  localparam int PERIOD_W = 16;
  localparam int PROD_W   = DUTY_W + PERIOD_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] OP_ON         = 4'd0;
  localparam logic [3:0] OP_OFF        = 4'd1;
  localparam logic [3:0] OP_TOGGLE     = 4'd2;
  localparam logic [3:0] OP_BLINK      = 4'd3;
  localparam logic [3:0] OP_BLINK_ONCE = 4'd4;
  localparam logic [3:0] OP_FLASH      = 4'd5;
  localparam logic [3:0] OP_TICK       = 4'd6;
  localparam logic [3:0] OP_SLEEP      = 4'd7;
  localparam logic [3:0] OP_WAKE       = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd2;

  localparam logic [COUNT_W-1:0]  RST_FLASH_COUNT = 8'd50;
  localparam logic [PCT_W-1:0]    RST_DUTY        = 8'd5;
  localparam logic [PERIOD_W-1:0] RST_PERIOD      = 16'd1000;

  localparam logic [PCT_W-1:0]  PCT_FULL  = 8'd100;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  localparam int MODE_ON    = 0;
  localparam int MODE_BLINK = 1;
  localparam int MODE_CONT  = 2;
  localparam logic [2:0] MODE_LIT  = 3'b001;
  localparam logic [2:0] MODE_DARK = 3'b000;

  // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30 for every x below 2^23
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [MASK_W-1:0]   led_mask;
    logic [COUNT_W-1:0]  blink_count;
    logic [PCT_W-1:0]    on_percent;
    logic [PERIOD_W-1:0] period_ms;
  } lbc_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] led_outputs;
    logic [MASK_W-1:0] blinking_mask;
  } lbc_out_t;

  typedef struct packed {
    logic                step;
    logic                set_on;
    logic                set_off;
    logic                toggle;
    logic                load;
    logic                tick;
    logic                sleep;
    logic                wake;
    logic                service;
    logic [COUNT_W-1:0]  count;
    logic [PERIOD_W-1:0] on_len;
    logic [PERIOD_W-1:0] off_len;
  } lbc_cmd_t;

  typedef struct packed {
    logic led;
    logic blinking;
  } lbc_stat_t;

  function automatic logic [PERIOD_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] q;
    q = (PROD_W + RECIP_W)'(x) * (PROD_W + RECIP_W)'(RECIP_100);
    return q[RECIP_SHIFT +: PERIOD_W];
  endfunction

endpackage

// ===== src/lbc_lane.sv =====
// State and next-state logic of one LED: mode, blink counters and phase timer.
`timescale 1ns / 1ps
module lbc_lane import lbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lbc_cmd_t  cmd,
  input  logic      sel,
  output lbc_stat_t stat
);

  logic [2:0]          mode, mode_next;
  logic                led, led_next;
  logic                pre, pre_next;
  logic                saved, saved_next;
  logic [COUNT_W-1:0]  blinks, blinks_next;
  logic [PERIOD_W-1:0] ticks, ticks_next;
  logic [PERIOD_W-1:0] on_len, on_len_next;
  logic [PERIOD_W-1:0] off_len, off_len_next;

  always_comb begin
    mode_next    = mode;
    led_next     = led;
    pre_next     = pre;
    saved_next   = saved;
    blinks_next  = blinks;
    ticks_next   = ticks;
    on_len_next  = on_len;
    off_len_next = off_len;

    if (sel && cmd.set_on) begin
      mode_next = MODE_LIT;
      led_next  = 1'b1;
    end
    if (sel && cmd.set_off) begin
      mode_next = MODE_DARK;
      led_next  = 1'b0;
    end
    if (sel && cmd.toggle) begin
      mode_next[MODE_ON] = ~mode[MODE_ON];
      led_next           = ~mode[MODE_ON];
    end
    if (sel && cmd.load) begin
      if (!mode[MODE_BLINK] && !mode[MODE_CONT]) begin
        pre_next = pre | led;
      end
      mode_next    = {(cmd.count == '0), 1'b1, 1'b0};
      on_len_next  = cmd.on_len;
      off_len_next = cmd.off_len;
      blinks_next  = cmd.count;
      ticks_next   = '0;
    end
    if (cmd.tick && ticks != '0) begin
      ticks_next = ticks - PERIOD_W'(1);
    end
    if (cmd.sleep) begin
      saved_next = led;
      led_next   = 1'b0;
    end
    if (cmd.wake) begin
      led_next = led | saved;
    end

    // advance the blink phase once its timer has run out
    if (cmd.service && mode_next[MODE_BLINK] && ticks_next == '0) begin
      if (mode_next[MODE_ON]) begin
        mode_next[MODE_ON] = 1'b0;
        led_next           = 1'b0;
        if (!mode_next[MODE_CONT]) begin
          blinks_next = blinks_next - COUNT_W'(1);
        end
        ticks_next = off_len_next;
      end else if (blinks_next == '0 && !mode_next[MODE_CONT]) begin
        mode_next  = pre_next ? MODE_LIT : MODE_DARK;
        led_next   = pre_next;
        ticks_next = '0;
        pre_next   = 1'b0;
      end else begin
        mode_next[MODE_ON] = 1'b1;
        led_next           = 1'b1;
        ticks_next         = on_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_DARK;
      led   <= 1'b0;
      pre   <= 1'b0;
      saved <= 1'b0;
      ticks <= '0;
    end else if (cmd.step) begin
      mode  <= mode_next;
      led   <= led_next;
      pre   <= pre_next;
      saved <= saved_next;
      ticks <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      blinks  <= blinks_next;
      on_len  <= on_len_next;
      off_len <= off_len_next;
    end
  end

  assign stat.led      = led_next;
  assign stat.blinking = mode_next[MODE_BLINK];

endmodule

// ===== src/led_blink_controller_core.sv =====
// Top level of the LED blink controller: request register, LED lanes, result register.
// Request flow: a request is captured in the request register and, once the result register
// is free, its result is registered there, where it can be taken.
// Throughput: one request per cycle while cmd_stall is low; the phase-length products are
// formed at the request register and divided by 100 ahead of the lane update.
// Reset: synchronous; all LEDs off, not blinking, awake, defaults 50 / 5 / 1000.
`timescale 1ns / 1ps
module led_blink_controller_core import lbc_pkg::*; #(
  parameter int NUM_LEDS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  lbc_in_t               cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output lbc_out_t              res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [3:0]         opcode;
    logic [MASK_W-1:0]  mask;
    logic [COUNT_W-1:0] count;
    logic               zero;
    logic               full;
    logic [PROD_W-1:0]  on_prod;
    logic [PROD_W-1:0]  off_prod;
  } stage_t;

  logic [COUNT_W-1:0]  dflt_count;
  logic [PCT_W-1:0]    dflt_pct;
  logic [PERIOD_W-1:0] dflt_period;

  stage_t              stage, stage_next;
  logic                stage_valid;
  logic                sleep_active;
  logic                res_free, accept, adv;
  logic [COUNT_W-1:0]  eff_count;
  logic [PCT_W-1:0]    eff_pct;
  logic [PERIOD_W-1:0] eff_period;
  logic [DUTY_W-1:0]   duty;
  logic                blink_op;
  logic [NUM_LEDS-1:0] sel_vec, led_vec, blink_vec;
  logic [MASK_W-1:0]   led_res, blink_res;
  lbc_cmd_t            ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_count  <= RST_FLASH_COUNT;
      dflt_pct    <= RST_DUTY;
      dflt_period <= RST_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLASH_COUNT: dflt_count  <= cfg_data[COUNT_W-1:0];
        CFG_DUTY:        dflt_pct    <= cfg_data[PCT_W-1:0];
        CFG_PERIOD:      dflt_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_free  = !res_valid || !res_stall;
  assign adv       = stage_valid && res_free;
  assign cmd_stall = stage_valid && !res_free;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    case (cmd.opcode)
      OP_BLINK_ONCE: begin
        eff_count  = COUNT_W'(1);
        eff_pct    = dflt_pct;
        eff_period = dflt_period;
      end
      OP_FLASH: begin
        eff_count  = dflt_count;
        eff_pct    = dflt_pct;
        eff_period = dflt_period;
      end
      default: begin
        eff_count  = cmd.blink_count;
        eff_pct    = cmd.on_percent;
        eff_period = cmd.period_ms;
      end
    endcase
    duty                = eff_pct[DUTY_W-1:0];
    stage_next.opcode   = cmd.opcode;
    stage_next.mask     = cmd.led_mask;
    stage_next.count    = eff_count;
    stage_next.zero     = (eff_pct == '0) || (eff_period == '0);
    stage_next.full     = (eff_pct >= PCT_FULL);
    stage_next.on_prod  = PROD_W'(duty) * PROD_W'(eff_period);
    stage_next.off_prod = PROD_W'(DUTY_W'(DUTY_FULL - duty)) * PROD_W'(eff_period);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  always_comb begin
    blink_op = (stage.opcode == OP_BLINK) || (stage.opcode == OP_BLINK_ONCE) ||
               (stage.opcode == OP_FLASH);
    ctl.step    = adv;
    ctl.set_on  = (stage.opcode == OP_ON) || (blink_op && !stage.zero && stage.full);
    ctl.set_off = (stage.opcode == OP_OFF) || (blink_op && stage.zero);
    ctl.toggle  = (stage.opcode == OP_TOGGLE);
    ctl.load    = blink_op && !stage.zero && !stage.full;
    ctl.tick    = (stage.opcode == OP_TICK);
    ctl.sleep   = (stage.opcode == OP_SLEEP);
    ctl.wake    = (stage.opcode == OP_WAKE);
    ctl.service = ctl.wake ||
                  (!sleep_active && (ctl.tick || (ctl.load && (|sel_vec))));
    ctl.count   = stage.count;
    ctl.on_len  = div100(stage.on_prod);
    ctl.off_len = div100(stage.off_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_active <= 1'b0;
    end else if (adv && ctl.sleep) begin
      sleep_active <= 1'b1;
    end else if (adv && ctl.wake) begin
      sleep_active <= 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
    lbc_stat_t stat;
    if (i < MASK_W) begin : g_sel
      assign sel_vec[i] = stage.mask[i];
    end else begin : g_nosel
      assign sel_vec[i] = 1'b0;
    end
    lbc_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (ctl),
      .sel  (sel_vec[i]),
      .stat (stat)
    );
    assign led_vec[i]   = stat.led;
    assign blink_vec[i] = stat.blinking;
  end

  for (genvar i = 0; i < MASK_W; i++) begin : g_res
    if (i < NUM_LEDS) begin : g_used
      assign led_res[i]   = led_vec[i];
      assign blink_res[i] = blink_vec[i];
    end else begin : g_unused
      assign led_res[i]   = 1'b0;
      assign blink_res[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.led_outputs   <= led_res;
      res.blinking_mask <= blink_res;
    end
  end

endmodule

// ===== src/lbc_checker.sv =====
// Port-level checks of the LED blink controller, bound to the top level.
`timescale 1ns / 1ps
module lbc_checker import lbc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_stall,
  input logic     res_valid,
  input logic     res_stall,
  input lbc_out_t res
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid && !cmd_stall)
    else $error("result or stall left active after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("request stalled without a blocked result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) ##1 !res_stall |=> res_valid)
    else $error("accepted request gave no result");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result dropped or changed");

endmodule

bind led_blink_controller_core lbc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
